// ===== src/kts_pkg.sv =====
`default_nettype none
package kts_pkg;

    localparam int KTS_KEYS = 64;

    // command and field widths fixed by the interface
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int WORD_W  = 32;
    localparam int BLEND_W = 17;
    localparam int FRAC_W  = 16;

    // configuration register indexes
    localparam logic CFG_KEY_COUNT = 1'b0;
    localparam logic CFG_DURATION  = 1'b1;

    // beat kinds on s_tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic load;       // write slot from accepted beat
        logic start;      // latch query, seed search
        logic rd_next;    // read key frame+1
        logic step;       // frame <= frame + 1
        logic rd_a;       // read key frame, work out next
        logic rd_b;       // read key next
        logic cap_a;      // capture key before
        logic cap_b;      // capture key after, form gap and offset
        logic save_start; // cache frame for the next search
        logic f_one;      // factor saturates at one
        logic div_init;
        logic div_step;
        logic mul;
        logic acc;
        logic emit;
    } kts_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_lt2;
        logic frame_last;
        logic ge_next;
        logic div_skip;
        logic div_sat;
        logic div_done;
        logic comp_last;
        logic out_busy;
    } kts_sts_t;

endpackage
`default_nettype wire

// ===== src/kts_ctrl.sv =====
`default_nettype none
module kts_ctrl
    import kts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_kind,
    output logic          in_ready,
    input  wire kts_sts_t sts,
    output kts_cmd_t      cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_RA   = 4'd3;
    localparam logic [3:0] S_RB   = 4'd4;
    localparam logic [3:0] S_GAP  = 4'd5;
    localparam logic [3:0] S_DCHK = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ADD  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == CMD_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        if (sts.n_zero)
                            state_next = S_MUL;
                        else if (sts.n_lt2)
                            state_next = S_RA;
                        else
                            state_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                if (sts.frame_last)
                begin
                    state_next = S_RA;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (sts.ge_next)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SRD;
                end
                else
                begin
                    state_next = S_RA;
                end
            end
            S_RA:
            begin
                cmd.rd_a       = 1'b1;
                cmd.save_start = !sts.n_lt2;
                state_next     = S_RB;
            end
            S_RB:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = S_GAP;
            end
            S_GAP:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (sts.n_lt2 || sts.div_skip)
                begin
                    state_next = S_MUL;
                end
                else if (sts.div_sat)
                begin
                    cmd.f_one  = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.comp_last ? S_OUT : S_MUL;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !sts.out_busy)
        else $error("result emitted over an untaken beat");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_IDLE)
        else $error("no return to idle after emit");

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCMP |-> $past(cmd.rd_next))
        else $error("compare without a search read");

    a_div_from_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && $past(state_reg) != S_DIV) |-> $past(cmd.div_init))
        else $error("divide entered without init");

endmodule
`default_nettype wire

// ===== src/kts_dp.sv =====
`default_nettype none
module kts_dp
    import kts_pkg::*;
#(
    parameter int KEYS = KTS_KEYS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kts_cmd_t            cmd,
    output kts_sts_t                 sts,
    input  wire logic                cfg_we,
    input  wire logic                cfg_sel,
    input  wire logic [WORD_W-1:0]   cfg_wdata,
    input  wire logic [IDX_W-1:0]    in_index,
    input  wire logic [WORD_W-1:0]   in_time,
    input  wire logic [WORD_W-1:0]   in_x,
    input  wire logic [WORD_W-1:0]   in_y,
    input  wire logic [WORD_W-1:0]   in_z,
    input  wire logic [WORD_W-1:0]   in_query,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [WORD_W-1:0]        out_x,
    output logic [WORD_W-1:0]        out_y,
    output logic [WORD_W-1:0]        out_z,
    output logic [IDX_W-1:0]         out_before,
    output logic [IDX_W-1:0]         out_after,
    output logic [BLEND_W-1:0]       out_blend
);

    localparam int AW  = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CW  = $clog2(KEYS + 1);
    localparam int EW  = 4 * WORD_W;
    localparam int GW  = WORD_W + 2;
    localparam int PW  = WORD_W + 1 + BLEND_W + 1;
    localparam int SW  = PW - FRAC_W;

    // configuration
    logic [CNT_W-1:0]  key_count_reg;
    logic [WORD_W-1:0] duration_reg;
    logic [CW-1:0]     n_keys;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            duration_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_sel == CFG_KEY_COUNT)
                key_count_reg <= cfg_wdata[CNT_W-1:0];
            else
                duration_reg <= cfg_wdata;
        end
    end

    assign n_keys = (32'(key_count_reg) > KEYS) ? CW'(KEYS) : CW'(key_count_reg);

    // key memory, entry is {time, z, y, x}
    logic [EW-1:0]     mem [KEYS];
    logic [EW-1:0]     rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     raddr;

    logic [AW-1:0]     frame_reg;
    logic [AW-1:0]     next_reg;
    logic [AW-1:0]     cache_reg;
    logic [WORD_W-1:0] prev_reg;
    logic [WORD_W-1:0] query_reg;

    assign mem_we = cmd.load && (32'(in_index) < KEYS);
    assign mem_re = cmd.rd_next || cmd.rd_a || cmd.rd_b;

    always_comb
    begin
        if (cmd.rd_next)
            raddr = frame_reg + AW'(1);
        else if (cmd.rd_b)
            raddr = next_reg;
        else
            raddr = frame_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AW'(in_index)] <= {in_time, in_z, in_y, in_x};
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // search bookkeeping
    logic [AW-1:0] seed;
    logic          frame_last;

    assign seed       = (in_query >= prev_reg) ? cache_reg : '0;
    assign frame_last = (CW'(frame_reg) + CW'(1)) == n_keys;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_reg <= '0;
            prev_reg  <= '0;
            frame_reg <= '0;
            next_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                prev_reg  <= in_query;
                frame_reg <= (CW'(seed) >= n_keys) ? '0 : seed;
                next_reg  <= '0;
            end
            else if (cmd.step)
            begin
                frame_reg <= frame_reg + AW'(1);
            end
            if (cmd.rd_a)
                next_reg <= frame_last ? '0 : frame_reg + AW'(1);
            if (cmd.save_start)
                cache_reg <= frame_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            query_reg <= in_query;
    end

    // key vectors, gap and offset
    logic signed [WORD_W-1:0] a_vec [3];
    logic signed [WORD_W-1:0] b_vec [3];
    logic [WORD_W-1:0]        ta_reg;
    logic signed [GW-1:0]     gap_reg;
    logic signed [GW-1:0]     ofs_reg;
    logic signed [GW-1:0]     gap_raw;

    assign gap_raw = $signed({2'b00, rdata_reg[EW-1 -: WORD_W]}) - $signed({2'b00, ta_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_vec[c] <= '0;
                b_vec[c] <= '0;
            end
        end
        if (cmd.cap_a)
        begin
            for (int c = 0; c < 3; c++)
                a_vec[c] <= rdata_reg[c*WORD_W +: WORD_W];
            ta_reg <= rdata_reg[EW-1 -: WORD_W];
        end
        if (cmd.cap_b)
        begin
            for (int c = 0; c < 3; c++)
                b_vec[c] <= rdata_reg[c*WORD_W +: WORD_W];
            gap_reg <= gap_raw[GW-1] ? gap_raw + $signed({2'b00, duration_reg}) : gap_raw;
            ofs_reg <= $signed({2'b00, query_reg}) - $signed({2'b00, ta_reg});
        end
    end

    // factor: restoring divide, one quotient bit a cycle, offset below gap
    logic [BLEND_W-1:0] f_reg;
    logic [WORD_W:0]    rem_reg;
    logic [WORD_W:0]    rem_sh;
    logic [3:0]         div_cnt_reg;
    logic               q_bit;

    assign rem_sh = {rem_reg[WORD_W-1:0], 1'b0};
    assign q_bit  = rem_sh >= gap_reg[WORD_W:0];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            f_reg <= '0;
        else if (cmd.f_one)
            f_reg <= BLEND_W'(1 << FRAC_W);
        else if (cmd.div_step)
            f_reg <= {f_reg[BLEND_W-2:0], q_bit};
        if (cmd.div_init)
        begin
            rem_reg     <= ofs_reg[WORD_W:0];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= q_bit ? rem_sh - gap_reg[WORD_W:0] : rem_sh;
            div_cnt_reg <= div_cnt_reg + 4'd1;
        end
    end

    // blend, one component at a time through a shared multiplier, multiply then accumulate
    logic [1:0]                comp_reg;
    logic signed [WORD_W:0]    diff;
    logic signed [PW-1:0]      prod_reg;
    logic signed [SW-1:0]      sum;
    logic signed [WORD_W-1:0]  res [3];
    logic signed [WORD_W-1:0]  a_sel;

    assign a_sel = a_vec[comp_reg];
    assign diff  = $signed({b_vec[comp_reg][WORD_W-1], b_vec[comp_reg]})
                 - $signed({a_sel[WORD_W-1], a_sel});
    assign sum   = $signed({{(SW-WORD_W){a_sel[WORD_W-1]}}, a_sel})
                 + prod_reg[PW-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            comp_reg <= '0;
        else if (cmd.acc)
            comp_reg <= comp_reg + 2'd1;
        if (cmd.mul)
            prod_reg <= diff * $signed({1'b0, f_reg});
        if (cmd.acc)
        begin
            if (sum > $signed(SW'(32'sh7FFF_FFFF)))
                res[comp_reg] <= 32'sh7FFF_FFFF;
            else if (sum < $signed(-(SW'(64'sh8000_0000))))
                res[comp_reg] <= 32'sh8000_0000;
            else
                res[comp_reg] <= sum[WORD_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x      <= res[0];
            out_y      <= res[1];
            out_z      <= res[2];
            out_before <= IDX_W'(frame_reg);
            out_after  <= IDX_W'(next_reg);
            out_blend  <= f_reg;
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.n_zero     = (n_keys == '0);
        sts.n_lt2      = (n_keys < CW'(2));
        sts.frame_last = frame_last;
        sts.ge_next    = query_reg >= rdata_reg[EW-1 -: WORD_W];
        sts.div_skip   = (gap_reg <= 0) || (ofs_reg <= 0);
        sts.div_sat    = ofs_reg >= gap_reg;
        sts.div_done   = (div_cnt_reg == 4'd15);
        sts.comp_last  = (comp_reg == 2'd2);
        sts.out_busy   = out_valid && !out_ready;
    end

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_next |-> (CW'(frame_reg) + CW'(1)) < n_keys)
        else $error("search read past last key");

    a_factor_max: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> f_reg <= BLEND_W'(1 << FRAC_W))
        else $error("blend factor above one");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_x) && $stable(out_blend))
        else $error("result beat dropped while stalled");

endmodule
`default_nettype wire

// ===== src/keyframe_track_sampler.sv =====
`default_nettype none
// channel   | direction | beat contents
// s_*       | in        | load keyframe or sample query, kind on s_tuser
// m_*       | out       | one interpolated result per sample query
// cfg_*     | in        | register write: 0 key_count, 1 duration_ticks
//
// a load is written into the key memory at acceptance
// a sample with two or more keys runs a search, then the factor divide and the
//   blend; each search step is one memory read plus compare, the factor divide
//   yields one quotient bit per step and is skipped when the factor is zero or
//   one, and the blend multiplies then accumulates each axis in turn
// s_tready rises in the same cycle that the result appears in the output register
// reset clears control, config and the search cache; keys are undefined until loaded
// a stalled result holds in the output register while the next beat is taken
module keyframe_track_sampler
    import kts_pkg::*;
#(
    parameter int KEYS = KTS_KEYS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // key_index, key_time, key_x, key_y, key_z, sample_time, zero fill
    input  wire logic [167:0] s_tdata,
    // command
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z, key_before, key_after, blend_factor, zero fill
    output logic [127:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [31:0]  cfg_data
);

    kts_cmd_t cmd;
    kts_sts_t sts;

    logic [WORD_W-1:0]  res_x;
    logic [WORD_W-1:0]  res_y;
    logic [WORD_W-1:0]  res_z;
    logic [IDX_W-1:0]   res_before;
    logic [IDX_W-1:0]   res_after;
    logic [BLEND_W-1:0] res_blend;

    // config writes land at once
    assign cfg_ready = 1'b1;

    kts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kts_dp #(
        .KEYS (KEYS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_sel    (cfg_index),
        .cfg_wdata  (cfg_data),
        .in_index   (s_tdata[5:0]),
        .in_time    (s_tdata[37:6]),
        .in_x       (s_tdata[69:38]),
        .in_y       (s_tdata[101:70]),
        .in_z       (s_tdata[133:102]),
        .in_query   (s_tdata[165:134]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_x      (res_x),
        .out_y      (res_y),
        .out_z      (res_z),
        .out_before (res_before),
        .out_after  (res_after),
        .out_blend  (res_blend)
    );

    assign m_tdata = {3'b000, res_blend, res_after, res_before, res_z, res_y, res_x};

endmodule
`default_nettype wire
